### hw/rtl/tdwa_pkg.sv
`timescale 1ns / 1ps
// Package for the top-down window allocator: sizes, index widths, op and status codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package tdwa_pkg;

    localparam int ALLOC_SLOTS = 8;
    localparam int RAM_REGIONS = 16;
    localparam int PAGE_BITS   = 12;

    localparam int ADDR_W = 64;
    localparam int PAGE_W = 52;

    localparam int GIDX_W = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
    localparam int GCNT_W = $clog2(ALLOC_SLOTS + 1);
    localparam int RIDX_W = (RAM_REGIONS > 1) ? $clog2(RAM_REGIONS) : 1;
    localparam int RCNT_W = $clog2(RAM_REGIONS + 1);
    localparam int PASS_W = $clog2(ALLOC_SLOTS + 2);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ALLOC  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD     = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_RAM     = 3'd3,
        ST_RAMFULL = 3'd4
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    ram_clear;
        logic    ram_append;
        logic    init_cand;
        logic    start_pass;
        logic    grant_next;
        logic    move_cand;
        logic    ram_start;
        logic    ram_next;
        logic    record;
        logic    set_result;
        logic    use_cand;
        status_t result_status;
        logic    out_load;
    } tdwa_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad;
        logic       ram_full;
        logic       below_ws;
        logic       pass_cap;
        logic       gscan_done;
        logic       gconflict;
        logic       rscan_done;
        logic       rhit;
        logic       out_free;
    } tdwa_stat_t;

endpackage

### hw/rtl/tdwa_datapath.sv
`timescale 1ns / 1ps
// Datapath of the top-down window allocator: captured item, grant and RAM tables,
// candidate arithmetic, scan counters and the output register. Depends on tdwa_pkg.
module tdwa_datapath
    import tdwa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tdwa_cmd_t           cmd,
    output tdwa_stat_t          stat,
    input  logic [1:0]          op,
    input  logic [ADDR_W-1:0]   window_start,
    input  logic [ADDR_W-1:0]   window_end,
    input  logic [ADDR_W-1:0]   range_size,
    input  logic [PAGE_W-1:0]   ram_first_page,
    input  logic [PAGE_W-1:0]   ram_last_page,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ADDR_W-1:0]   granted_base,
    output logic [2:0]          status
);

    logic [1:0]        op_reg;
    logic [ADDR_W-1:0] ws_reg;
    logic [ADDR_W-1:0] we_reg;
    logic [ADDR_W-1:0] size_reg;
    logic [PAGE_W-1:0] first_page_reg;
    logic [PAGE_W-1:0] last_page_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] cand_reg;
    logic [ADDR_W-1:0] cand_end_reg;

    logic [ADDR_W-1:0] gbase_reg [ALLOC_SLOTS];
    logic [ADDR_W-1:0] gend_reg  [ALLOC_SLOTS];
    logic [PAGE_W-1:0] rstart_reg [RAM_REGIONS];
    logic [PAGE_W-1:0] rend_reg   [RAM_REGIONS];

    logic [GCNT_W-1:0] grant_count_reg, grant_count_next;
    logic [GCNT_W-1:0] gidx_reg, gidx_next;
    logic [RCNT_W-1:0] ram_count_reg, ram_count_next;
    logic [RCNT_W-1:0] ridx_reg, ridx_next;
    logic [PASS_W-1:0] pass_reg, pass_next;

    logic [ADDR_W-1:0] res_base_reg;
    status_t           res_status_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_base_reg;
    status_t           out_status_reg;

    logic [ADDR_W-1:0] size_m1;
    logic [ADDR_W-1:0] cur_gbase;
    logic [ADDR_W-1:0] cur_gend;
    logic [ADDR_W-1:0] ram_lo;
    logic [ADDR_W-1:0] ram_hi;

    assign size_m1   = size_reg - ADDR_W'(1);
    assign cur_gbase = gbase_reg[gidx_reg[GIDX_W-1:0]];
    assign cur_gend  = gend_reg[gidx_reg[GIDX_W-1:0]];
    assign ram_lo    = {{(ADDR_W-PAGE_W){1'b0}}, rstart_reg[ridx_reg[RIDX_W-1:0]]} << PAGE_BITS;
    assign ram_hi    = {{(ADDR_W-PAGE_W){1'b0}}, rend_reg[ridx_reg[RIDX_W-1:0]]} << PAGE_BITS;

    always_comb
    begin
        stat.op         = op_reg;
        stat.bad        = (grant_count_reg == GCNT_W'(ALLOC_SLOTS)) || (size_reg == '0)
                          || ((size_reg & size_m1) != '0) || (we_reg < size_reg);
        stat.ram_full   = (ram_count_reg == RCNT_W'(RAM_REGIONS));
        stat.below_ws   = (cand_reg < ws_reg);
        stat.pass_cap   = (pass_reg == PASS_W'(ALLOC_SLOTS + 1));
        stat.gscan_done = (gidx_reg == grant_count_reg);
        stat.gconflict  = (cand_reg < cur_gend) && (cur_gbase < cand_end_reg);
        stat.rscan_done = (ridx_reg == ram_count_reg);
        stat.rhit       = (cand_reg < ram_hi) && (ram_lo < cand_end_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        grant_count_next = grant_count_reg;
        gidx_next        = gidx_reg;
        ram_count_next   = ram_count_reg;
        ridx_next        = ridx_reg;
        pass_next        = pass_reg;
        out_valid_next   = out_valid_reg;
        if (cmd.capture)
        begin
            pass_next = '0;
        end
        if (cmd.ram_clear)
        begin
            ram_count_next = '0;
        end
        if (cmd.ram_append)
        begin
            ram_count_next = ram_count_reg + RCNT_W'(1);
        end
        if (cmd.start_pass)
        begin
            pass_next = pass_reg + PASS_W'(1);
            gidx_next = '0;
        end
        if (cmd.grant_next)
        begin
            gidx_next = gidx_reg + GCNT_W'(1);
        end
        if (cmd.ram_start)
        begin
            ridx_next = '0;
        end
        if (cmd.ram_next)
        begin
            ridx_next = ridx_reg + RCNT_W'(1);
        end
        if (cmd.record)
        begin
            grant_count_next = grant_count_reg + GCNT_W'(1);
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_count_reg <= '0;
            gidx_reg        <= '0;
            ram_count_reg   <= '0;
            ridx_reg        <= '0;
            pass_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            grant_count_reg <= grant_count_next;
            gidx_reg        <= gidx_next;
            ram_count_reg   <= ram_count_next;
            ridx_reg        <= ridx_next;
            pass_reg        <= pass_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= op;
            ws_reg         <= window_start;
            we_reg         <= window_end;
            size_reg       <= range_size;
            first_page_reg <= ram_first_page;
            last_page_reg  <= ram_last_page;
        end
        if (cmd.init_cand)
        begin
            mask_reg <= ~size_m1;
            cand_reg <= (we_reg - size_reg) & ~size_m1;
        end
        if (cmd.start_pass)
        begin
            cand_end_reg <= cand_reg + size_reg;
        end
        if (cmd.move_cand)
        begin
            cand_reg <= (cur_gbase - size_reg) & mask_reg;
        end
        if (cmd.ram_append)
        begin
            rstart_reg[ram_count_reg[RIDX_W-1:0]] <= first_page_reg;
            rend_reg[ram_count_reg[RIDX_W-1:0]]   <= last_page_reg;
        end
        if (cmd.record)
        begin
            gbase_reg[grant_count_reg[GIDX_W-1:0]] <= cand_reg;
            gend_reg[grant_count_reg[GIDX_W-1:0]]  <= cand_end_reg;
        end
        if (cmd.set_result)
        begin
            res_base_reg   <= cmd.use_cand ? cand_reg : '0;
            res_status_reg <= cmd.result_status;
        end
        if (cmd.out_load)
        begin
            out_base_reg   <= res_base_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_base = out_base_reg;
    assign status       = out_status_reg;

endmodule

### hw/rtl/tdwa_ctrl.sv
`timescale 1ns / 1ps
// Controller of the top-down window allocator: a one-hot state machine that steps
// the datapath through decode, grant scan passes, RAM scan and result hand-off.
// Depends on tdwa_pkg.
module tdwa_ctrl
    import tdwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  tdwa_stat_t stat,
    output tdwa_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_PASS   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_RAM    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.result_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_DONE;
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.ram_clear = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        if (stat.ram_full)
                        begin
                            cmd.result_status = ST_RAMFULL;
                        end
                        else
                        begin
                            cmd.ram_append = 1'b1;
                        end
                    end
                    OP_ALLOC:
                    begin
                        if (stat.bad)
                        begin
                            cmd.result_status = ST_BAD;
                        end
                        else
                        begin
                            cmd.set_result = 1'b0;
                            cmd.init_cand  = 1'b1;
                            state_next     = S_PASS;
                        end
                    end
                    default:
                    begin
                        cmd.result_status = ST_OK;
                    end
                endcase
            end
            S_PASS:
            begin
                if (stat.below_ws || stat.pass_cap)
                begin
                    cmd.set_result    = 1'b1;
                    cmd.result_status = ST_NOSPACE;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.start_pass = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (stat.gscan_done)
                begin
                    cmd.ram_start = 1'b1;
                    state_next    = S_RAM;
                end
                else if (stat.gconflict)
                begin
                    cmd.move_cand = 1'b1;
                    state_next    = S_PASS;
                end
                else
                begin
                    cmd.grant_next = 1'b1;
                end
            end
            S_RAM:
            begin
                priority if (stat.rscan_done)
                begin
                    cmd.record     = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.use_cand   = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.rhit)
                begin
                    cmd.set_result    = 1'b1;
                    cmd.result_status = ST_RAM;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.ram_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### hw/rtl/top_down_window_allocator.sv
`timescale 1ns / 1ps
// Top-down window allocator: each input item clears or extends the RAM region table or
// asks for an aligned range; exactly one result item (granted_base, status) comes back.
// Usage:
//   The input channel (in_valid, in_stall) takes one item at a time; in_stall is high
//   from the cycle after acceptance until the block is back in its idle state.
//   The output channel (out_valid, out_stall) is fed from an output register. A result
//   waiting there does not hold up the next input item, but that item's own result
//   waits until the register is taken.
//   Clear, append and unused ops, and a rejected allocation, go from decode straight
//   to the result. An allocation scans the grant table in up to 9 passes, then the
//   RAM region table; each table is compared one entry a cycle by its own compare unit.
//   Reset empties the grant and RAM tables and drops any pending result.
//   When the receiver stalls, the result stays stable in the output register.
// Depends on tdwa_pkg, tdwa_ctrl and tdwa_datapath.
module top_down_window_allocator
    import tdwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] window_start,
    input  logic [ADDR_W-1:0] window_end,
    input  logic [ADDR_W-1:0] range_size,
    input  logic [PAGE_W-1:0] ram_first_page,
    input  logic [PAGE_W-1:0] ram_last_page,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] granted_base,
    output logic [2:0]        status
);

    tdwa_cmd_t  cmd;
    tdwa_stat_t stat;

    tdwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdwa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .window_start   (window_start),
        .window_end     (window_end),
        .range_size     (range_size),
        .ram_first_page (ram_first_page),
        .ram_last_page  (ram_last_page),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_base   (granted_base),
        .status         (status)
    );

endmodule
